/* src/mlt_pkg.sv */
package mlt_pkg;

  localparam int MAX_PLAYERS = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int IDX_W       = 7;
  localparam int ADDR_W      = 6;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_BUILD   = 2'd1;
  localparam logic [1:0] MODE_REPLACE = 2'd2;
  localparam logic [1:0] MODE_UPDATE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic write_key;
    logic start;
    logic node_rd;
    logic key_rd;
    logic match_wr;
    logic out_rd;
    logic out_load;
  } mlt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wr_en;
    logic replay;
    logic last;
    logic out_busy;
  } mlt_sts_t;

endpackage

/* src/mlt_ctrl.sv */
module mlt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  mlt_pkg::mlt_sts_t sts,
  output mlt_pkg::mlt_cmd_t cmd
);
  import mlt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRITE  = 3'd1;
  localparam logic [2:0] S_NREAD  = 3'd2;
  localparam logic [2:0] S_KREAD  = 3'd3;
  localparam logic [2:0] S_MATCH  = 3'd4;
  localparam logic [2:0] S_OREAD  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_key = sts.wr_en;
        cmd.start     = sts.replay;
        state_next    = sts.replay ? S_NREAD : S_OREAD;
      end
      S_NREAD: begin
        cmd.node_rd = 1'b1;
        state_next  = S_KREAD;
      end
      S_KREAD: begin
        cmd.key_rd = 1'b1;
        state_next = S_MATCH;
      end
      S_MATCH: begin
        cmd.match_wr = 1'b1;
        state_next   = sts.last ? S_OREAD : S_NREAD;
      end
      S_OREAD: begin
        cmd.out_rd = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/mlt_datapath.sv */
module mlt_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mlt_pkg::IDX_W-1:0]           cfg_wr_data,
  input  logic [1:0]                          in_mode,
  input  logic [mlt_pkg::IDX_W-1:0]           in_index,
  input  logic signed [mlt_pkg::KEY_WIDTH-1:0] in_key,
  input  mlt_pkg::mlt_cmd_t                   cmd,
  output mlt_pkg::mlt_sts_t                   sts,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [mlt_pkg::IDX_W-1:0]           out_index,
  output logic signed [mlt_pkg::KEY_WIDTH-1:0] out_key,
  output logic                                out_ready_flag
);
  import mlt_pkg::*;

  logic signed [KEY_WIDTH-1:0] key_mem [0:MAX_PLAYERS-1];
  logic [IDX_W-1:0] node_win [0:MAX_PLAYERS-1];
  logic [IDX_W-1:0] node_los [0:MAX_PLAYERS-1];

  logic [IDX_W-1:0] n;
  logic [7:0]       low, loff;
  logic             built;
  logic [IDX_W-1:0] ow;
  logic [1:0]       mode_r;
  logic [IDX_W-1:0] idx_r;
  logic signed [KEY_WIDTH-1:0] key_r;
  logic [ADDR_W-1:0] p;
  logic             wpath;
  logic [IDX_W-1:0] cur;

  // Node read stage.
  logic             lq_int, rq_int;
  logic [IDX_W-1:0] lext, rext, nwa, nwb, nlp;
  // Key read stage.
  logic [IDX_W-1:0] lc, rc;
  logic signed [KEY_WIDTH-1:0] ka, kb;

  logic             idx_ok, ow_ok, is_mode0, is_mode1, is_mode2, is_mode3;
  logic [IDX_W-1:0] wr_player, nm1, s_pow, sat_n, left_c, right_c, win, los;
  logic [7:0]       diff, low_b, loff_b, player8, pos, ql, qr, lext_b, rext_b;
  logic [ADDR_W-1:0] rda_addr, rdb_addr;
  logic             less;

  assign is_mode0 = (mode_r == MODE_LOAD);
  assign is_mode1 = (mode_r == MODE_BUILD);
  assign is_mode2 = (mode_r == MODE_REPLACE);
  assign is_mode3 = (mode_r == MODE_UPDATE);
  assign idx_ok   = (idx_r != '0) && ({1'b0, idx_r} <= 8'(MAX_PLAYERS));
  assign ow_ok    = (ow != '0) && ({1'b0, ow} <= 8'(MAX_PLAYERS));
  assign wr_player = is_mode2 ? ow : idx_r;

  assign sts.wr_en  = ((is_mode0 || is_mode3) && idx_ok) || (is_mode2 && built && ow_ok);
  assign sts.replay = is_mode1 || (is_mode2 && built && ow_ok) ||
                      (is_mode3 && idx_ok && built && (idx_r <= n));
  assign sts.last     = (p == ADDR_W'(1));
  assign sts.out_busy = m_tvalid && !m_tready;

  // Layout of the tree: s is the largest power of two not above N-1.
  assign nm1 = n - IDX_W'(1);
  always_comb begin
    s_pow = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (nm1[i]) begin
        s_pow = IDX_W'(1) << i;
      end
    end
  end
  assign diff   = {1'b0, n} - {1'b0, s_pow};
  assign low_b  = {diff[6:0], 1'b0};
  assign loff_b = {s_pow, 1'b0} - 8'd1;

  assign player8 = {1'b0, wr_player};
  assign pos = (player8 <= low) ? (loff + player8) : (player8 - low + {1'b0, nm1});

  // External contestants of the two children of node p.
  assign ql     = {1'b0, p, 1'b0};
  assign qr     = ql + 8'd1;
  assign lext_b = (ql > loff) ? (ql - loff) : (ql - {1'b0, nm1} + low);
  assign rext_b = (qr > loff) ? (qr - loff) : (qr - {1'b0, nm1} + low);

  assign left_c  = wpath ? nlp : (lq_int ? nwa : lext);
  assign right_c = wpath ? cur : (rq_int ? nwb : rext);

  assign rda_addr = cmd.out_rd ? ADDR_W'(ow - IDX_W'(1)) : ADDR_W'(left_c - IDX_W'(1));
  assign rdb_addr = ADDR_W'(right_c - IDX_W'(1));

  assign less = (kb < ka);
  assign win  = less ? rc : lc;
  assign los  = less ? lc : rc;

  always_comb begin
    sat_n = cfg_wr_data;
    if (cfg_wr_data < IDX_W'(2)) begin
      sat_n = IDX_W'(2);
    end else if ({1'b0, cfg_wr_data} > 8'(MAX_PLAYERS)) begin
      sat_n = IDX_W'(MAX_PLAYERS);
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.write_key) begin
      key_mem[ADDR_W'(wr_player - IDX_W'(1))] <= key_r;
    end
    if (cmd.key_rd || cmd.out_rd) begin
      ka <= key_mem[rda_addr];
    end
    if (cmd.key_rd) begin
      kb <= key_mem[rdb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match_wr) begin
      node_win[p] <= win;
      node_los[p] <= los;
    end
    if (cmd.node_rd) begin
      nwa <= node_win[ql[ADDR_W-1:0]];
      nwb <= node_win[qr[ADDR_W-1:0]];
      nlp <= node_los[p];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      idx_r  <= in_index;
      key_r  <= in_key;
    end
    if (cmd.start) begin
      wpath <= is_mode2 || (is_mode3 && (idx_r == ow));
      cur   <= wr_player;
      p     <= is_mode1 ? ADDR_W'(nm1) : pos[ADDR_W:1];
    end else if (cmd.match_wr) begin
      cur <= win;
      p   <= wpath ? (p >> 1) : (is_mode1 ? p - ADDR_W'(1) : p >> 1);
    end
    if (cmd.node_rd) begin
      lq_int <= (ql < {1'b0, n});
      rq_int <= (qr < {1'b0, n});
      lext   <= lext_b[IDX_W-1:0];
      rext   <= rext_b[IDX_W-1:0];
    end
    if (cmd.key_rd) begin
      lc <= left_c;
      rc <= right_c;
    end
    if (cmd.out_load) begin
      out_index      <= built ? ow : '0;
      out_key        <= built ? ka : '0;
      out_ready_flag <= built;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      n        <= IDX_W'(2);
      low      <= '0;
      loff     <= '0;
      built    <= 1'b0;
      ow       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        n     <= sat_n;
        built <= 1'b0;
        ow    <= '0;
      end
      if (cmd.start && is_mode1) begin
        low  <= low_b;
        loff <= loff_b;
      end
      if (cmd.match_wr && sts.last) begin
        ow    <= win;
        built <= 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* src/min_loser_tree_merge_selector.sv */
// Minimum loser tree over up to 64 signed 32-bit keys, the selector of a
// k-way merge. Each input transaction carries a mode in s_tuser: load a key
// (mode 0), build the tree over the configured number of players (mode 1),
// replace the current winner's key and replay its path (mode 2), or change
// any player's key and replay (mode 3). On equal keys the left contestant
// wins. Every transaction yields one output transaction with the winner's
// index and key in m_tdata and the built flag in m_tuser; before a build
// the index and key read as zero. Items are handled one at a time. A load,
// or any item that does not replay, goes from the write state to the output
// read and result states. Each replayed tree node takes a node memory read,
// a key memory read, and a compare with write back; a replay walks the path
// from the player to the root, and a build walks each of the N-1 internal
// nodes. The next item is accepted as soon as the result is in the output
// register, even if it has not yet been taken. Write players_in_use through
// cfg_wr_en/cfg_wr_data only while the block is idle; a write clears the
// built flag.
module min_loser_tree_merge_selector (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // players_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,       // [6:0] player_index, [38:7] key_value
  input  logic [1:0]  s_tuser,       // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,       // [6:0] winner_index, [38:7] winner_key
  output logic        m_tuser        // [0] tree_ready
);
  import mlt_pkg::*;

  mlt_cmd_t cmd;
  mlt_sts_t sts;
  logic [IDX_W-1:0] out_index;
  logic signed [KEY_WIDTH-1:0] out_key;
  logic out_ready_flag;

  mlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlt_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_mode        (s_tuser),
    .in_index       (s_tdata[6:0]),
    .in_key         (s_tdata[38:7]),
    .cmd            (cmd),
    .sts            (sts),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .out_index      (out_index),
    .out_key        (out_key),
    .out_ready_flag (out_ready_flag)
  );

  // The spare top bit of the byte-aligned payload is always zero.
  assign m_tdata = {1'b0, out_key, out_index};
  assign m_tuser = out_ready_flag;

endmodule

/* src/mlt_checker.sv */
module mlt_assertions (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // Without a built tree the result is all zero.
  a_unbuilt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 40'd0)
    else $error("nonzero result before build");

  // A built tree always names a real player.
  a_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[6:0] != 7'd0)
    else $error("winner index zero on built tree");

  // Items are taken one at a time: no accept right after an accept.
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("back-to-back accept");

endmodule

bind min_loser_tree_merge_selector mlt_assertions u_mlt_assertions (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
